@@ rtl/core/psched_pkg.sv @@
// Shared types and sizes for the priority schedule timing block.
// No dependencies; every rtl/core module imports this package.
package psched_pkg;

    localparam int MAX_JOBS = 16;
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int NUM_W    = 5;
    localparam int PRIO_W   = 8;
    localparam int BURST_W  = 16;
    localparam int TIME_W   = 20;
    localparam int TOT_W    = 24;
    localparam int MEAN_W   = 28;
    localparam int DIVD_W   = TOT_W + 8;
    localparam int STEP_W   = $clog2(DIVD_W + 1);

    typedef struct packed {
        logic [BURST_W-1:0] burst_time;
        logic [PRIO_W-1:0]  prio_level;
        logic               last;
    } t_in_beat;

    typedef struct packed {
        logic [NUM_W-1:0]   proc_number;
        logic [PRIO_W-1:0]  rank_priority;
        logic [BURST_W-1:0] run_time;
        logic [TIME_W-1:0]  wait_time;
        logic [TIME_W-1:0]  turnaround_time;
        logic [MEAN_W-1:0]  mean_wait;
        logic [MEAN_W-1:0]  mean_turnaround;
        logic               end_of_run;
        logic               overflow;
    } t_out_beat;

    typedef struct packed {
        logic [NUM_W-1:0]   number;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
    } t_job;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

endpackage

@@ rtl/core/psched_cell.sv @@
// One slot of the sorted job chain.
// Depends on psched_pkg.
module psched_cell
    import psched_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_job      i_new,
    input  logic      i_prev_valid,
    input  logic      i_prev_le,
    input  t_job      i_prev,
    input  logic      i_next_valid,
    input  t_job      i_next,
    output logic      o_valid,
    output logic      o_le,
    output t_job      o_job
);

    logic r_valid, n_valid;
    t_job r_job, n_job;

    // Entry sorts at or ahead of the new job: it stays put.
    assign o_le = r_valid && (r_job.prio <= i_new.prio);

    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        if (i_ctl.ins && !o_le) begin
            if (i_prev_le) begin
                n_valid = 1'b1;
                n_job   = i_new;
            end else begin
                n_valid = i_prev_valid;
                n_job   = i_prev;
            end
        end else if (i_ctl.shift) begin
            n_valid = i_next_valid;
            n_job   = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;

endmodule

@@ rtl/core/psched_div.sv @@
// Bit-serial restoring divider for the two batch averages, one bit per cycle.
// Depends on psched_pkg.
module psched_div
    import psched_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TOT_W-1:0]  i_tot_a,
    input  logic [TOT_W-1:0]  i_tot_b,
    input  logic [CNT_W-1:0]  i_count,
    output logic              o_done,
    output logic [MEAN_W-1:0] o_mean_a,
    output logic [MEAN_W-1:0] o_mean_b
);

    logic [DIVD_W-1:0] r_qa, r_qb;
    logic [CNT_W:0]    r_ra, r_rb;
    logic [CNT_W-1:0]  r_d;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic [CNT_W:0]    n_ta, n_tb;

    assign n_ta = {r_ra[CNT_W-1:0], r_qa[DIVD_W-1]};
    assign n_tb = {r_rb[CNT_W-1:0], r_qb[DIVD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(DIVD_W);
        end else if (r_busy) begin
            r_step <= r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_qa <= {i_tot_a, 8'd0};
            r_qb <= {i_tot_b, 8'd0};
            r_ra <= '0;
            r_rb <= '0;
            r_d  <= i_count;
        end else if (r_busy) begin
            // shift in one dividend bit, subtract when it fits
            if (n_ta >= {1'b0, r_d}) begin
                r_ra <= n_ta - {1'b0, r_d};
                r_qa <= {r_qa[DIVD_W-2:0], 1'b1};
            end else begin
                r_ra <= n_ta;
                r_qa <= {r_qa[DIVD_W-2:0], 1'b0};
            end
            if (n_tb >= {1'b0, r_d}) begin
                r_rb <= n_tb - {1'b0, r_d};
                r_qb <= {r_qb[DIVD_W-2:0], 1'b1};
            end else begin
                r_rb <= n_tb;
                r_qb <= {r_qb[DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign o_done   = !r_busy;
    assign o_mean_a = r_qa[MEAN_W-1:0];
    assign o_mean_b = r_qb[MEAN_W-1:0];

endmodule

@@ rtl/core/priority_schedule_timing.sv @@
// Non-preemptive priority scheduler timing block: top level.
// Depends on psched_pkg, psched_cell and psched_div.
//
// Jobs arrive one beat per cycle on the input channel while it is ready and
// drop straight into a chain of MAX_JOBS cells that keeps them sorted by
// priority (lower value first, ties in arrival order). A beat with last set
// closes the batch: the input then stalls while the chain shifts its head out,
// one result beat per cycle as the output takes them. Before the final result
// of a batch the two averages are formed by a bit-serial divider, once per
// batch. Jobs beyond MAX_JOBS are dropped and flag overflow on every result of
// that batch.
module priority_schedule_timing
    import psched_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_EMIT = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_left;
    logic [NUM_W-1:0]  r_arr;
    logic              r_drop;
    logic [TIME_W-1:0] r_elapsed;
    logic [TOT_W-1:0]  r_wtot, r_ttot;
    logic [TOT_W-1:0]  n_wtot, n_ttot;
    logic              r_out_valid;
    t_out_beat         r_out;
    t_out_beat         r_hold;

    logic      in_take, out_free, emit, div_start, div_done;
    logic      store;
    t_job      new_job;
    t_cell_ctl ctl;
    logic [TIME_W-1:0] tat;
    logic [MEAN_W-1:0] mean_w, mean_t;

    logic [MAX_JOBS-1:0] c_valid, c_le;
    t_job                c_job [MAX_JOBS];

    assign o_ready  = (r_state == S_LOAD);
    assign in_take  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign emit     = (r_state == S_EMIT) && out_free;
    assign store    = in_take && (r_count < CNT_W'(MAX_JOBS));

    assign new_job.number = r_arr + 1'b1;
    assign new_job.prio   = i_data.prio_level;
    assign new_job.burst  = i_data.burst_time;

    assign ctl.ins   = store;
    assign ctl.shift = emit;

    // Sorted chain: cell 0 is the head of the schedule.
    for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
        psched_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_new        (new_job),
            .i_prev_valid (g == 0 ? 1'b1 : c_valid[(g == 0) ? 0 : g - 1]),
            .i_prev_le    (g == 0 ? 1'b1 : c_le[(g == 0) ? 0 : g - 1]),
            .i_prev       (c_job[(g == 0) ? 0 : g - 1]),
            .i_next_valid (g == MAX_JOBS - 1 ? 1'b0
                           : c_valid[(g == MAX_JOBS - 1) ? g : g + 1]),
            .i_next       (c_job[(g == MAX_JOBS - 1) ? g : g + 1]),
            .o_valid      (c_valid[g]),
            .o_le         (c_le[g]),
            .o_job        (c_job[g])
        );
    end

    // Head job timing.
    assign tat    = r_elapsed + TIME_W'(c_job[0].burst);
    assign n_wtot = r_wtot + TOT_W'(r_elapsed);
    assign n_ttot = r_ttot + TOT_W'(tat);
    assign div_start = emit && (r_left == CNT_W'(1));

    psched_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_tot_a  (n_wtot),
        .i_tot_b  (n_ttot),
        .i_count  (r_count),
        .o_done   (div_done),
        .o_mean_a (mean_w),
        .o_mean_b (mean_t)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_left      <= '0;
            r_arr       <= '0;
            r_drop      <= 1'b0;
            r_elapsed   <= '0;
            r_wtot      <= '0;
            r_ttot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // raise valid on a fresh result beat, drop it once taken
            if ((emit && !div_start) || ((r_state == S_FIN) && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_take) begin
                        // count jobs; a full chain drops the beat and flags it
                        if (store) begin
                            r_count <= r_count + 1'b1;
                            r_arr   <= r_arr + 1'b1;
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_data.last) begin
                            r_left  <= store ? r_count + 1'b1 : r_count;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (emit) begin
                        r_elapsed <= tat;
                        r_wtot    <= n_wtot;
                        r_ttot    <= n_ttot;
                        r_left    <= r_left - 1'b1;
                        if (div_start) begin
                            // hold the final beat until the averages are in
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_count     <= '0;
                        r_arr       <= '0;
                        r_drop      <= 1'b0;
                        r_elapsed   <= '0;
                        r_wtot      <= '0;
                        r_ttot      <= '0;
                        r_state     <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_hold.proc_number     <= c_job[0].number;
            r_hold.rank_priority   <= c_job[0].prio;
            r_hold.run_time        <= c_job[0].burst;
            r_hold.wait_time       <= r_elapsed;
            r_hold.turnaround_time <= tat;
            r_hold.mean_wait       <= '0;
            r_hold.mean_turnaround <= '0;
            r_hold.end_of_run      <= 1'b0;
            r_hold.overflow        <= r_drop;
            r_out.proc_number      <= c_job[0].number;
            r_out.rank_priority    <= c_job[0].prio;
            r_out.run_time         <= c_job[0].burst;
            r_out.wait_time        <= r_elapsed;
            r_out.turnaround_time  <= tat;
            r_out.mean_wait        <= '0;
            r_out.mean_turnaround  <= '0;
            r_out.end_of_run       <= 1'b0;
            r_out.overflow         <= r_drop;
        end else if ((r_state == S_FIN) && out_free) begin
            r_out <= '{proc_number:     r_hold.proc_number,
                       rank_priority:   r_hold.rank_priority,
                       run_time:        r_hold.run_time,
                       wait_time:       r_hold.wait_time,
                       turnaround_time: r_hold.turnaround_time,
                       mean_wait:       mean_w,
                       mean_turnaround: mean_t,
                       end_of_run:      1'b1,
                       overflow:        r_hold.overflow};
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

@@ test/testbench.sv @@
// Testbench for priority_schedule_timing: drives job beats, predicts schedule order and times.
// Depends on psched_pkg and the RTL top level priority_schedule_timing.
`timescale 1ns / 100ps

module testbench;
    import psched_pkg::*;

    // Schedule predictor and store of expected result beats.
    class sched_board;
        t_job        chain[$];
        logic        dropped;
        int unsigned arrivals;
        t_out_beat   pending[$];
        int unsigned errors;
        int unsigned results_seen;
        int unsigned batches;

        function new();
            chain = {};
            dropped = 0;
            arrivals = 0;
            errors = 0;
            results_seen = 0;
            batches = 0;
        endfunction

        // Insert one accepted job; on last, expand the batch into result beats.
        function void note_job(t_in_beat b);
            t_job        j;
            int          pos;
            logic [23:0] wsum;
            logic [23:0] tsum;
            logic [19:0] elapsed;
            t_out_beat   r;
            int          n;
            if (chain.size() < MAX_JOBS) begin
                arrivals++;
                j.number = arrivals[NUM_W-1:0];
                j.prio = b.prio_level;
                j.burst = b.burst_time;
                pos = chain.size();
                while (pos > 0 && chain[pos-1].prio > b.prio_level)
                    pos--;
                chain.insert(pos, j);
            end else begin
                dropped = 1'b1;
            end
            if (!b.last)
                return;
            n = chain.size();
            wsum = 0;
            tsum = 0;
            elapsed = 0;
            for (int k = 0; k < n; k++) begin
                r = '0;
                r.proc_number = chain[k].number;
                r.rank_priority = chain[k].prio;
                r.run_time = chain[k].burst;
                r.wait_time = elapsed;
                r.turnaround_time = elapsed + chain[k].burst;
                wsum = wsum + elapsed;
                tsum = tsum + r.turnaround_time;
                elapsed = r.turnaround_time;
                r.overflow = dropped;
                if (k == n - 1) begin
                    r.mean_wait = 28'({8'd0, wsum, 8'd0} / n);
                    r.mean_turnaround = 28'({8'd0, tsum, 8'd0} / n);
                    r.end_of_run = 1'b1;
                end
                pending.push_back(r);
            end
            chain = {};
            dropped = 1'b0;
            arrivals = 0;
            batches++;
        endfunction

        // Compare one result beat with the oldest expectation.
        function void check_result(t_out_beat got);
            t_out_beat exp_beat;
            results_seen++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat %h", $time, got);
                return;
            end
            exp_beat = pending.pop_front();
            if (got !== exp_beat) begin
                errors++;
                $display("%0t: result mismatch expected %h actual %h", $time, exp_beat, got);
                $display("  num %0d/%0d prio %0d/%0d run %0d/%0d wait %0d/%0d tat %0d/%0d",
                    exp_beat.proc_number, got.proc_number, exp_beat.rank_priority,
                    got.rank_priority, exp_beat.run_time, got.run_time,
                    exp_beat.wait_time, got.wait_time, exp_beat.turnaround_time,
                    got.turnaround_time);
                $display("  mw %0d/%0d mt %0d/%0d eor %0b/%0b ovf %0b/%0b",
                    exp_beat.mean_wait, got.mean_wait, exp_beat.mean_turnaround,
                    got.mean_turnaround, exp_beat.end_of_run, got.end_of_run,
                    exp_beat.overflow, got.overflow);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_beat o_data;

    sched_board  board;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    int unsigned cycle_count;
    int unsigned jobs_sent;

    priority_schedule_timing dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: end the run if it hangs.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: sample at the rising edge, change ready at the falling edge.
    initial begin
        i_ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                board.check_result(o_data);
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                i_ready <= 0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offer one job beat, with a random idle gap first; hold until accepted.
    task automatic send_job(input logic [15:0] burst, input logic [7:0] prio, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_data <= '{burst_time: burst, prio_level: prio, last: last};
        do @(posedge i_clk); while (!(o_ready && i_valid));
        board.note_job(i_data);
        jobs_sent++;
        @(negedge i_clk);
    endtask

    // Random batch of n_jobs jobs with priorities up to prio_span; the last beat closes it.
    task automatic send_batch(input int n_jobs, input int prio_span);
        logic [15:0] burst;
        for (int k = 0; k < n_jobs; k++) begin
            case ($urandom_range(9))
                0: burst = 16'hFFFF;
                1: burst = 0;
                default: burst = 16'($urandom);
            endcase
            send_job(burst, 8'($urandom_range(prio_span)), k == n_jobs - 1);
        end
    endtask

    // Wait until every expected result has arrived, plus a short tail.
    task automatic drain();
        i_valid <= 0;
        while (board.pending.size() != 0)
            @(negedge i_clk);
        repeat (50) @(negedge i_clk);
    endtask

    task automatic random_phase(input int idle, input int stall, input int n_items);
        int target;
        int size;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        target = jobs_sent + n_items;
        while (jobs_sent < target) begin
            size = ($urandom_range(19) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 16);
            send_batch(size, ($urandom_range(1)) ? 3 : 255);
        end
    endtask

    initial begin
        board = new();
        i_rst_n = 0;
        i_valid = 0;
        i_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        jobs_sent = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: single job, extremes, ties, then full store plus dropped jobs.
        send_job(16'hFFFF, 8'hFF, 1);
        send_job(16'h0000, 8'h00, 1);
        send_job(16'h5555, 8'hAA, 0);
        send_job(16'hAAAA, 8'h55, 0);
        send_job(16'h0001, 8'h55, 1);
        for (int k = 0; k < 18; k++)
            send_job(16'(16'hFFFF - k), 8'(17 - k), k == 17);
        drain();

        // Long receiver hold-off while the sender keeps offering beats.
        hold_off_cycles = 300;
        send_batch(16, 255);
        send_batch(5, 255);
        drain();

        random_phase(0, 0, 120);
        drain();
        random_phase(51, 0, 110);
        drain();
        random_phase(0, 51, 110);
        drain();
        random_phase(30, 30, 110);
        drain();

        $display("Covered %0d jobs in %0d batches, %0d result beats checked.",
            jobs_sent, board.batches, board.results_seen);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
